// File: hw/rtl/gbg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gbg_pkg
// Shared types, widths and codes of the greedy batch grouper.
// ---------------------------------------------------------------------------
package gbg_pkg;

    // field widths
    localparam int AtomW   = 8;
    localparam int TorsW   = 6;
    localparam int NodeW   = 8;
    localparam int ConfW   = 8;
    localparam int ChgW    = 8;
    localparam int CountW  = 16;
    localparam int PpiW    = 7;
    localparam int TargetW = 16;
    localparam int MemW    = 48;
    localparam int CtxW    = 16;
    localparam int ReasonW = 2;

    // member count plus one
    localparam int MW      = CountW + 1;
    // pose total: (count+1) * poses_per_item
    localparam int PoseW   = MW + PpiW;
    // per-pose bytes plus the four bytes of pose overhead, at most 149952
    localparam int PerW    = 18;

    // shared multiplier operand and product widths
    localparam int OpaW    = PoseW;
    localparam int OpbW    = PerW;
    localparam int ProdW   = OpaW + OpbW;

    // stream payload widths
    localparam int InDataW  = 40;
    localparam int OutDataW = 80;
    localparam int OutUserW = 3;

    // configuration port
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = MemW;

    typedef logic [CfgIdxW-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_POSES_PER_ITEM = 2'd0;
    localparam cfg_idx_t REG_POSE_TARGET    = 2'd1;
    localparam cfg_idx_t REG_MEMORY_LIMIT   = 2'd2;
    localparam cfg_idx_t REG_CONTEXT_BYTES  = 2'd3;

    // close reasons, first that holds wins
    typedef logic [ReasonW-1:0] reason_t;
    localparam reason_t REASON_NONE  = 2'd0;
    localparam reason_t REASON_POSES = 2'd1;
    localparam reason_t REASON_MEM   = 2'd2;
    localparam reason_t REASON_RATIO = 2'd3;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HC,
        ST_POSE,
        ST_MEM,
        ST_CTX,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/gbg_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gbg_mul
// Shared unsigned multiplier with a registered product.
// ---------------------------------------------------------------------------
module gbg_mul
    import gbg_pkg::*;
(
    input  wire logic             clk,
    input  wire logic [OpaW-1:0]  opa,
    input  wire logic [OpbW-1:0]  opb,
    output logic      [ProdW-1:0] prod
);

    logic [ProdW-1:0] prod_reg;

    // one product per cycle, registered
    always_ff @(posedge clk)
    begin
        prod_reg <= ProdW'(opa) * ProdW'(opb);
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

// File: hw/rtl/greedy_batch_grouper_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// greedy_batch_grouper_core
// Packs size-sorted work items greedily into batches, one result per item.
// ---------------------------------------------------------------------------
// Each item passes through the sequencer in order: the idle state in which
// it is accepted, four passes through a single shared registered multiplier
// (change triangle, pose total, pose memory, context memory) and a final
// state to sum, decide the close reason and update the batch state, at the
// end of which the result is loaded into the output register. The input is
// ready only while the sequencer is idle, so a new item is not taken before
// the last result is loaded; the result sits in an output register, so the
// next item is taken while an earlier result still waits downstream. A
// result that is not taken holds the sequencer in its final state.
// ---------------------------------------------------------------------------
module greedy_batch_grouper_core
    import gbg_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration writes
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_wdata,
    // input items
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    // atom_count[7:0], torsion_count[13:8], node_count[21:14],
    // conf_len[29:22], change_size[37:30], zero[39:38]
    input  wire logic [InDataW-1:0]  s_axis_tdata,
    // results
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    // batch_number[15:0], position_in_batch[31:16], estimated_memory[79:32]
    output logic [OutDataW-1:0]      m_axis_tdata,
    // starts_new_batch[0], close_reason[2:1]
    output logic [OutUserW-1:0]      m_axis_tuser
);

    // configuration registers
    logic [PpiW-1:0]    ppi_reg;
    logic [TargetW-1:0] pose_target_reg;
    logic [MemW-1:0]    mem_limit_reg;
    logic [CtxW-1:0]    ctx_bytes_reg;

    // batch state
    logic [CountW-1:0]  member_count_reg;
    logic [CountW-1:0]  batch_index_reg;
    logic [AtomW-1:0]   max_atoms_reg;
    logic [AtomW-1:0]   min_atoms_reg;
    logic [TorsW-1:0]   max_tors_reg;
    logic [NodeW-1:0]   max_nodes_reg;
    logic [ConfW-1:0]   max_conf_reg;
    logic [ChgW-1:0]    max_chg_reg;

    // latched item
    logic [AtomW-1:0]   atom_reg;
    logic [TorsW-1:0]   tors_reg;
    logic [NodeW-1:0]   node_reg;
    logic [ConfW-1:0]   conf_reg;
    logic [ChgW-1:0]    chg_reg;

    // intermediate results
    logic [PerW-1:0]    per_reg;
    logic [PoseW-1:0]   pose_reg;
    logic [ProdW-1:0]   acc_reg;

    // output register
    logic               out_valid_reg;
    logic [OutDataW-1:0] out_data_reg;
    logic [OutUserW-1:0] out_user_reg;

    state_t state_reg;
    state_t state_next;

    logic [OpaW-1:0]  mul_a;
    logic [OpbW-1:0]  mul_b;
    logic [ProdW-1:0] mul_p;
    logic             in_take;
    logic             load_out;

    // running maxima and minimum including the item
    logic [AtomW-1:0] ta;
    logic [NodeW-1:0] tn;
    logic [ConfW-1:0] tc;
    logic [ChgW-1:0]  tg;
    logic [AtomW-1:0] lo;
    logic [MW-1:0]    m_val;
    logic [CountW-1:0] hc;
    logic [PerW-1:0]  per_val;
    logic [MemW-1:0]  est;
    logic             over_poses;
    logic             over_mem;
    logic             mismatch;
    logic             nonempty;
    reason_t          reason;
    logic             closing;

    assign ta = (atom_reg > max_atoms_reg) ? atom_reg : max_atoms_reg;
    assign tn = (node_reg > max_nodes_reg) ? node_reg : max_nodes_reg;
    assign tc = (conf_reg > max_conf_reg)  ? conf_reg : max_conf_reg;
    assign tg = (chg_reg > max_chg_reg)    ? chg_reg  : max_chg_reg;
    assign lo = (atom_reg < min_atoms_reg) ? atom_reg : min_atoms_reg;
    assign m_val = MW'(member_count_reg) + MW'(1);

    // change triangle from the first product, then per-pose bytes plus 4
    assign hc = mul_p[CountW:1];
    assign per_val = PerW'(12) * PerW'(tc) + PerW'(16) * PerW'(tg) + PerW'(4) * PerW'(hc)
                   + PerW'(24) * PerW'(ta) + PerW'(24) * PerW'(tn) + PerW'(12);

    // estimate stays below 2^42, no saturation reachable
    assign est = MemW'(acc_reg) + MemW'(mul_p);

    // close checks
    assign nonempty   = (member_count_reg != '0);
    assign over_poses = (pose_reg > PoseW'(pose_target_reg));
    assign over_mem   = (mem_limit_reg != '0) && (est > mem_limit_reg);
    assign mismatch   = (lo != '0) && ({1'b0, ta} > {lo, 1'b0});

    always_comb
    begin
        reason = REASON_NONE;
        if (nonempty)
        begin
            if (over_poses)
            begin
                reason = REASON_POSES;
            end
            else if (over_mem)
            begin
                reason = REASON_MEM;
            end
            else if (mismatch)
            begin
                reason = REASON_RATIO;
            end
        end
    end

    assign closing = (reason != REASON_NONE);

    // shared multiplier
    gbg_mul u_mul (
        .clk  (clk),
        .opa  (mul_a),
        .opb  (mul_b),
        .prod (mul_p)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ST_HC;
                end
            end
            ST_HC:   state_next = ST_POSE;
            ST_POSE: state_next = ST_MEM;
            ST_MEM:  state_next = ST_CTX;
            ST_CTX:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: multiplier operands and strobes
    always_comb
    begin
        mul_a    = '0;
        mul_b    = '0;
        in_take  = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_take = s_axis_tvalid;
            end
            ST_HC:
            begin
                mul_a = OpaW'(tg);
                mul_b = OpbW'(tg) + OpbW'(1);
            end
            ST_POSE:
            begin
                mul_a = OpaW'(m_val);
                mul_b = OpbW'(ppi_reg);
            end
            ST_MEM:
            begin
                mul_a = mul_p[PoseW-1:0];
                mul_b = per_reg;
            end
            ST_CTX:
            begin
                mul_a = OpaW'(m_val);
                mul_b = OpbW'(ctx_bytes_reg);
            end
            ST_DONE:
            begin
                // keep the context product steady while the result waits
                mul_a    = OpaW'(m_val);
                mul_b    = OpbW'(ctx_bytes_reg);
                load_out = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    // sequencer state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppi_reg         <= PpiW'(8);
            pose_target_reg <= TargetW'(2048);
            mem_limit_reg   <= '0;
            ctx_bytes_reg   <= CtxW'(256);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POSES_PER_ITEM: ppi_reg         <= cfg_wdata[PpiW-1:0];
                REG_POSE_TARGET:    pose_target_reg <= cfg_wdata[TargetW-1:0];
                REG_MEMORY_LIMIT:   mem_limit_reg   <= cfg_wdata[MemW-1:0];
                REG_CONTEXT_BYTES:  ctx_bytes_reg   <= cfg_wdata[CtxW-1:0];
                default:            ppi_reg         <= ppi_reg;
            endcase
        end
    end

    // batch state, updated as the result is loaded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            member_count_reg <= '0;
            batch_index_reg  <= '0;
            max_atoms_reg    <= '0;
            min_atoms_reg    <= '1;
            max_tors_reg     <= '0;
            max_nodes_reg    <= '0;
            max_conf_reg     <= '0;
            max_chg_reg      <= '0;
        end
        else if (load_out)
        begin
            if (closing)
            begin
                if (batch_index_reg != '1)
                begin
                    batch_index_reg <= batch_index_reg + CountW'(1);
                end
                member_count_reg <= CountW'(1);
                max_atoms_reg    <= atom_reg;
                min_atoms_reg    <= atom_reg;
                max_tors_reg     <= tors_reg;
                max_nodes_reg    <= node_reg;
                max_conf_reg     <= conf_reg;
                max_chg_reg      <= chg_reg;
            end
            else
            begin
                if (member_count_reg != '1)
                begin
                    member_count_reg <= member_count_reg + CountW'(1);
                end
                max_atoms_reg <= ta;
                min_atoms_reg <= lo;
                max_tors_reg  <= (tors_reg > max_tors_reg) ? tors_reg : max_tors_reg;
                max_nodes_reg <= tn;
                max_conf_reg  <= tc;
                max_chg_reg   <= tg;
            end
        end
    end

    // item latch, intermediates and result payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            atom_reg <= s_axis_tdata[7:0];
            tors_reg <= s_axis_tdata[13:8];
            node_reg <= s_axis_tdata[21:14];
            conf_reg <= s_axis_tdata[29:22];
            chg_reg  <= s_axis_tdata[37:30];
        end
        if (state_reg == ST_POSE)
        begin
            per_reg <= per_val;
        end
        if (state_reg == ST_MEM)
        begin
            pose_reg <= mul_p[PoseW-1:0];
        end
        if (state_reg == ST_CTX)
        begin
            acc_reg <= mul_p;
        end
        if (load_out)
        begin
            out_user_reg <= {reason, closing};
            out_data_reg <= {est,
                             closing ? CountW'(0) : member_count_reg,
                             (closing && batch_index_reg != '1)
                                 ? batch_index_reg + CountW'(1) : batch_index_reg};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

`ifndef ASSERT_OFF
    // a new batch always starts at position zero
    a_new_batch_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_user_reg[0]) |-> (out_data_reg[31:16] == '0))
        else $error("new batch result with nonzero position");

    // start flag agrees with the reason code
    a_flag_reason: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_user_reg[0] == (out_user_reg[2:1] != REASON_NONE)))
        else $error("start flag and close reason disagree");

    // memory check is off while the limit is zero
    a_mem_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && mem_limit_reg == '0) |-> (out_user_reg[2:1] != REASON_MEM))
        else $error("memory close with the limit disabled");

    // a nonempty batch keeps min atoms at or below max atoms
    a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
        (member_count_reg != '0) |-> (min_atoms_reg <= max_atoms_reg))
        else $error("batch minimum above maximum");

    // an accepted item runs the multiplier passes next
    a_seq_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (state_reg == ST_HC))
        else $error("sequencer did not start after accepting an item");
`endif

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for greedy_batch_grouper_core. A scripted table of jobs
// and register writes comes first, then random, mostly size-sorted job runs
// under several register settings. Every result beat is compared field by
// field against an in-bench batch placement predictor or a scripted want.
// ---------------------------------------------------------------------------
module testbench;
    import gbg_pkg::*;

    localparam int CYCLE_LIMIT   = 5_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int REPORT_LIMIT  = 40;
    localparam longint unsigned EST_MAX = 64'hFFFF_FFFF_FFFF;

    // one job as it travels in tdata, atom count in the low bits
    typedef struct packed {
        logic [7:0] change;
        logic [7:0] conf;
        logic [7:0] nodes;
        logic [5:0] torsions;
        logic [7:0] atoms;
    } job_t;

    // where a job lands and what the batch costs
    typedef struct packed {
        logic        starts_new;
        reason_t     reason;
        logic [15:0] batch_num;
        logic [15:0] position;
        logic [47:0] est_bytes;
    } placement_t;

    typedef enum logic {ROW_WRITE, ROW_JOB} row_kind_t;

    typedef struct {
        row_kind_t           kind;
        cfg_idx_t            idx;
        logic [CfgDataW-1:0] val;
        job_t                job;
        bit                  typed;
        placement_t          want;
    } script_row_t;

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [CfgIdxW-1:0]  cfg_index     = '0;
    logic [CfgDataW-1:0] cfg_wdata     = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [InDataW-1:0]  s_axis_tdata  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OutDataW-1:0] m_axis_tdata;
    logic [OutUserW-1:0] m_axis_tuser;

    // predictor copy of the registers
    int unsigned     ppi_now       = 8;
    int unsigned     target_now    = 2048;
    longint unsigned mem_limit_now = 0;
    int unsigned     ctx_now       = 256;

    // predictor copy of the batch state
    int unsigned members   = 0;
    int unsigned batch_now = 0;
    int unsigned atoms_hi  = 0;
    int unsigned atoms_lo  = 255;
    int unsigned tors_hi   = 0;
    int unsigned nodes_hi  = 0;
    int unsigned conf_hi   = 0;
    int unsigned change_hi = 0;

    placement_t  placements_due[$];
    script_row_t script_rows[$];
    int          fault_count = 0;
    bit          idling_on   = 1'b1;
    int unsigned rx_hold_len = 0;
    int unsigned cycles      = 0;

    greedy_batch_grouper_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int unsigned bigger(int unsigned a, int unsigned b);
        return (a > b) ? a : b;
    endfunction

    function automatic job_t job_of(int unsigned a, int unsigned t, int unsigned n,
                                    int unsigned c, int unsigned g);
        job_t j;
        j.atoms    = 8'(a);
        j.torsions = 6'(t);
        j.nodes    = 8'(n);
        j.conf     = 8'(c);
        j.change   = 8'(g);
        return j;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // decide close reason, batch slot and memory estimate, then fold the job in
    function automatic placement_t place_job(job_t j);
        longint unsigned m, p, ta, tn, tc, tg, tri_sum, per_pose, est;
        int unsigned     lo, hi;
        placement_t      res;
        m        = members + 1;
        p        = m * ppi_now;
        ta       = bigger(atoms_hi, j.atoms);
        tn       = bigger(nodes_hi, j.nodes);
        tc       = bigger(conf_hi, j.conf);
        tg       = bigger(change_hi, j.change);
        tri_sum  = tg * (tg + 1) / 2;
        per_pose = 12 * tc + 16 * tg + 4 * tri_sum + 24 * ta + 24 * tn + 8;
        est      = p * per_pose + m * ctx_now + 4 * p;
        if (est > EST_MAX)
            est = EST_MAX;
        lo = (atoms_lo < j.atoms) ? atoms_lo : j.atoms;
        hi = bigger(atoms_hi, j.atoms);

        // an empty batch is never closed
        res.reason = REASON_NONE;
        if (members != 0)
        begin
            if (p > target_now)
                res.reason = REASON_POSES;
            else if (mem_limit_now != 0 && est > mem_limit_now)
                res.reason = REASON_MEM;
            else if (lo != 0 && hi > 2 * lo)
                res.reason = REASON_RATIO;
        end

        if (res.reason != REASON_NONE)
        begin
            if (batch_now < 16'hFFFF)
                batch_now++;
            members   = 0;
            atoms_hi  = 0;
            atoms_lo  = 255;
            tors_hi   = 0;
            nodes_hi  = 0;
            conf_hi   = 0;
            change_hi = 0;
        end

        res.starts_new = (res.reason != REASON_NONE);
        res.batch_num  = 16'(batch_now);
        res.position   = 16'(members);
        res.est_bytes  = 48'(est);

        if (members < 16'hFFFF)
            members++;
        atoms_hi  = bigger(atoms_hi, j.atoms);
        atoms_lo  = (atoms_lo < j.atoms) ? atoms_lo : j.atoms;
        tors_hi   = bigger(tors_hi, j.torsions);
        nodes_hi  = bigger(nodes_hi, j.nodes);
        conf_hi   = bigger(conf_hi, j.conf);
        change_hi = bigger(change_hi, j.change);
        return res;
    endfunction

    task automatic add_write(cfg_idx_t idx, logic [CfgDataW-1:0] val);
        script_row_t row;
        row.kind  = ROW_WRITE;
        row.idx   = idx;
        row.val   = val;
        row.job   = '0;
        row.typed = 1'b0;
        row.want  = '0;
        script_rows.insert(script_rows.size(), row);
    endtask

    task automatic add_job(job_t j, bit typed = 1'b0, placement_t want = '0);
        script_row_t row;
        row.kind  = ROW_JOB;
        row.idx   = REG_POSES_PER_ITEM;
        row.val   = '0;
        row.job   = j;
        row.typed = typed;
        row.want  = want;
        script_rows.insert(script_rows.size(), row);
    endtask

    // register write, called only while the block is idle
    task automatic set_register(cfg_idx_t idx, logic [CfgDataW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            REG_POSES_PER_ITEM: ppi_now       = val[PpiW-1:0];
            REG_POSE_TARGET:    target_now    = val[TargetW-1:0];
            REG_MEMORY_LIMIT:   mem_limit_now = val;
            REG_CONTEXT_BYTES:  ctx_now       = val[CtxW-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // offer one job beat, valid stays up for a back-to-back follower
    task automatic offer_job(job_t j, bit typed, placement_t want);
        int unsigned pause;
        placement_t  predicted;
        pause = idling_on ? pick_gap() : 0;
        if (pause != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, j};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = place_job(j);
        placements_due.insert(placements_due.size(), typed ? want : predicted);
    endtask

    // stop offering and wait for every result to drain
    task automatic wait_batch_idle();
        s_axis_tvalid <= 1'b0;
        while (placements_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            if (fault_count < REPORT_LIMIT)
                $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    // result side ready: random stalls, plus a long hold on request
    initial
    begin : result_ready
        int unsigned stall_left;
        int unsigned hold;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_len != 0)
            begin
                hold        = rx_hold_len;
                rx_hold_len = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
                m_axis_tready <= 1'b1;
                stall_left = 0;
            end
            else if (stall_left != 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = idling_on ? pick_gap() : 0;
            end
        end
    end

    // compare each result beat against the oldest placement due
    initial
    begin : result_check
        placement_t want, got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.starts_new = m_axis_tuser[0];
                got.reason     = m_axis_tuser[2:1];
                got.batch_num  = m_axis_tdata[15:0];
                got.position   = m_axis_tdata[31:16];
                got.est_bytes  = m_axis_tdata[79:32];
                if (placements_due.size() == 0)
                begin
                    if (fault_count < REPORT_LIMIT)
                        $error("result beat with no job pending");
                    fault_count++;
                end
                else
                begin
                    want = placements_due.pop_front();
                    check_field("starts_new_batch", want.starts_new, got.starts_new);
                    check_field("close_reason", want.reason, got.reason);
                    check_field("batch_number", want.batch_num, got.batch_num);
                    check_field("position_in_batch", want.position, got.position);
                    check_field("estimated_memory", want.est_bytes, got.est_bytes);
                end
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : stimulus
        int unsigned         r;
        int unsigned         size_walk;
        job_t                j;
        logic [CfgDataW-1:0] ppi_val, tgt_val, mem_val, ctx_val;

        // reset defaults: first job lands in an empty batch
        add_job(job_of(0, 0, 0, 0, 0), 1'b1, '{1'b0, REASON_NONE, 16'd0, 16'd0, 48'd352});
        add_job(job_of(255, 63, 255, 255, 255));
        add_job(job_of(100, 21, 77, 3, 128));
        // zero pose target closes every nonempty batch
        add_write(REG_POSE_TARGET, 48'd0);
        add_job(job_of(10, 0, 0, 0, 0));
        add_job(job_of(10, 42, 170, 85, 170));
        // poses per item masked down to zero, no context: estimate is zero
        add_write(REG_POSES_PER_ITEM, 48'h80);
        add_write(REG_CONTEXT_BYTES, 48'd0);
        add_write(REG_POSE_TARGET, 48'd65535);
        // size ratio: exactly twice stays, one more closes, zero minimum skips it
        add_job(job_of(20, 5, 6, 7, 9), 1'b1, '{1'b0, REASON_NONE, 16'd2, 16'd1, 48'd0});
        add_job(job_of(21, 1, 2, 3, 4), 1'b1, '{1'b1, REASON_RATIO, 16'd3, 16'd0, 48'd0});
        add_job(job_of(0, 9, 9, 9, 9), 1'b1, '{1'b0, REASON_NONE, 16'd3, 16'd1, 48'd0});
        add_job(job_of(255, 63, 255, 255, 255), 1'b1,
                '{1'b0, REASON_NONE, 16'd3, 16'd2, 48'd0});
        // tiny memory limit
        add_write(REG_POSES_PER_ITEM, 48'd1);
        add_write(REG_MEMORY_LIMIT, 48'd1);
        add_job(job_of(0, 0, 0, 0, 0));
        add_job(job_of(0, 0, 0, 0, 0));
        // top of the memory limit and context byte ranges
        add_write(REG_MEMORY_LIMIT, 48'hFFFF_FFFF_FFFF);
        add_write(REG_POSES_PER_ITEM, 48'd64);
        add_write(REG_POSE_TARGET, 48'd2048);
        add_write(REG_CONTEXT_BYTES, 48'd65535);
        add_job(job_of(30, 4, 25, 40, 12));
        add_job(job_of(40, 11, 33, 47, 20));
        add_job(job_of(55, 17, 41, 60, 31));
        add_job(job_of(61, 2, 52, 63, 45));
        // all three reasons hold: pose target wins, then memory over ratio
        add_write(REG_POSE_TARGET, 48'd0);
        add_write(REG_MEMORY_LIMIT, 48'd1);
        add_write(REG_POSES_PER_ITEM, 48'd1);
        add_job(job_of(5, 3, 4, 5, 6));
        add_job(job_of(200, 30, 90, 120, 70));
        add_write(REG_POSE_TARGET, 48'd65535);
        add_job(job_of(1, 1, 1, 1, 1));
        add_job(job_of(2, 2, 2, 2, 2));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script_rows[i])
        begin
            if (script_rows[i].kind == ROW_WRITE)
            begin
                wait_batch_idle();
                set_register(script_rows[i].idx, script_rows[i].val);
            end
            else
            begin
                offer_job(script_rows[i].job, script_rows[i].typed, script_rows[i].want);
            end
        end

        // random phases, each under fresh register settings
        size_walk = 0;
        for (int phase = 0; phase < 8; phase++)
        begin
            wait_batch_idle();
            case ($urandom_range(0, 6))
                0: ppi_val = 48'd8;
                1: ppi_val = 48'd1;
                2: ppi_val = 48'd64;
                3: ppi_val = 48'($urandom_range(1, 64));
                4: ppi_val = {16'($urandom), 32'($urandom)};
                5: ppi_val = 48'd0;
                default: ppi_val = 48'hFF;
            endcase
            case ($urandom_range(0, 4))
                0: tgt_val = 48'd0;
                1: tgt_val = 48'd65535;
                2: tgt_val = 48'd2048;
                default: tgt_val = 48'($urandom_range(0, 800));
            endcase
            case ($urandom_range(0, 3))
                0: mem_val = 48'd0;
                1: mem_val = 48'hFFFF_FFFF_FFFF;
                default: mem_val = 48'($urandom_range(2000, 4_000_000));
            endcase
            case ($urandom_range(0, 3))
                0: ctx_val = 48'd256;
                1: ctx_val = 48'd0;
                2: ctx_val = 48'd65535;
                default: ctx_val = {32'($urandom), 16'($urandom)};
            endcase
            set_register(REG_POSES_PER_ITEM, ppi_val);
            set_register(REG_POSE_TARGET, tgt_val);
            set_register(REG_MEMORY_LIMIT, mem_val);
            set_register(REG_CONTEXT_BYTES, ctx_val);
            idling_on = (phase != 5);

            for (int k = 0; k < 212; k++)
            begin
                // long result hold while jobs keep coming
                if (phase == 2 && k == 40)
                    rx_hold_len = 400;
                // sender waits for a full drain mid-phase
                if (phase == 3 && k == 100)
                    wait_batch_idle();

                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    // noise: any value in any field
                    j = job_of($urandom_range(0, 255), $urandom_range(0, 63),
                               $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
                end
                else
                begin
                    // size-sorted run, restarting now and then
                    if (r < 22)
                        size_walk = $urandom_range(0, 40);
                    else if (size_walk < 252)
                        size_walk += $urandom_range(0, 3);
                    j = job_of(size_walk, $urandom_range(0, 63),
                               size_walk / 2 + $urandom_range(0, 20),
                               $urandom_range(0, 100), $urandom_range(0, 80));
                end
                offer_job(j, 1'b0, '0);
            end
        end

        wait_batch_idle();
        repeat (16) @(posedge clk);
        if (fault_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
hw/rtl/gbg_pkg.sv
hw/rtl/gbg_mul.sv
hw/rtl/greedy_batch_grouper_core.sv
verif/testbench.sv
